### hw/rtl/pcpd_pkg.sv
// -----------------------------------------------------------------------------
// pcpd_pkg
// Shared types and constants of the column-post picture decoder.
// -----------------------------------------------------------------------------
package pcpd_pkg;

   // Field widths fixed by the stream format
   localparam int BYTE_W     = 8;
   localparam int COL_W      = 11;
   localparam int Y_W        = 11;
   localparam int COLOUR_W   = 8;
   localparam int KIND_W     = 2;
   localparam int HEIGHT_W   = 12;

   // Packed stream widths
   localparam int REQ_DATA_W = 24;   // data_byte, column, zero fill
   localparam int REQ_USER_W = 1;    // column_start
   localparam int RSP_DATA_W = 32;   // pixel_x, pixel_y, colour, zero fill
   localparam int RSP_USER_W = 2;    // kind

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REMAP_ZERO   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLACK_INDEX  = 2'd2;

   localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 12'd1;
   localparam logic                REMAP_ZERO_RST   = 1'b1;
   localparam logic [BYTE_W-1:0]   BLACK_INDEX_RST  = 8'd0;

   // Largest picture side
   localparam int MAX_SIZE_DEF = 2048;

   // Top delta that ends a column
   localparam logic [BYTE_W-1:0] TERM_BYTE = 8'hFF;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TOP,
      PH_LEN,
      PH_SKIP1,
      PH_PIX,
      PH_SKIP2
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PIXEL,
      KIND_DONE,
      KIND_ERROR
   } kind_type;

endpackage

### hw/rtl/patch_column_post_decoder_unit.sv
// -----------------------------------------------------------------------------
// patch_column_post_decoder_unit
// Column-post picture decoder: one lump byte in, at most one pixel write,
// column-done or error result out.
// -----------------------------------------------------------------------------
// Takes one byte of column data per beat and walks the post structure of the
// column (top delta, length, unused byte, pixels, unused byte, 0xff end),
// with tall posts: a delta not above the current top is added to it. Every
// pixel byte gives a pixel write (colour 0 swapped for black_index when
// remap_zero is set), the 0xff end gives a column-done result, and a post
// running past min(image_height, MAX_SIZE) or a lump ending before the 0xff
// gives an error, after which all bytes are dropped until reset. A byte with
// req_tuser (column_start) set restarts the column from any phase.
// Throughput is one byte per clock while rsp_tready does not stall the output
// register: the byte is held in an input register while the post state machine
// updates on it, and the result is then loaded into the output register that
// drives rsp_tvalid. Only the output register stalling on rsp_tready slows
// intake. Registers are to be written over the csr port only while no byte is
// in flight; the user must ensure this, the block does not enforce it.
// -----------------------------------------------------------------------------
module patch_column_post_decoder_unit #(
   parameter int MAX_SIZE = pcpd_pkg::MAX_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pcpd_pkg::REQ_DATA_W-1:0]   req_tdata,  // [7:0] data_byte, [18:8] column
   input  logic [pcpd_pkg::REQ_USER_W-1:0]   req_tuser,  // [0] column_start
   input  logic                              req_tlast,  // lump_end
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pcpd_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [10:0] pixel_x, [21:11] pixel_y,
                                                          // [29:22] colour
   output logic [pcpd_pkg::RSP_USER_W-1:0]   rsp_tuser,  // [1:0] kind
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pcpd_pkg::CSR_DATA_W-1:0]   csr_data
);

   // post_top never exceeds the bound plus one delta byte
   localparam int TOP_W = $clog2(MAX_SIZE + 256);
   localparam int CMP_W = ((TOP_W > pcpd_pkg::HEIGHT_W) ? TOP_W : pcpd_pkg::HEIGHT_W) + 1;

   // ---------------------------------------------------------------- registers
   logic                             s1_valid_ff, s1_valid_in;
   logic [pcpd_pkg::BYTE_W-1:0]      s1_byte_ff;
   logic                             s1_start_ff;
   logic [pcpd_pkg::COL_W-1:0]       s1_col_ff;
   logic                             s1_last_ff;

   pcpd_pkg::phase_type              phase_ff, phase_in;
   logic                             top_none_ff, top_none_in;
   logic [TOP_W-1:0]                 post_top_ff, post_top_in;
   logic [TOP_W-1:0]                 row_ff, row_in;
   logic [pcpd_pkg::BYTE_W-1:0]      left_ff, left_in;
   logic                             failed_ff, failed_in;

   logic [pcpd_pkg::HEIGHT_W-1:0]    height_ff;
   logic                             remap_ff;
   logic [pcpd_pkg::BYTE_W-1:0]      black_ff;

   logic                             rsp_valid_ff, rsp_valid_in;
   pcpd_pkg::kind_type               kind_ff, kind_in;
   logic [pcpd_pkg::COL_W-1:0]       x_ff;
   logic [pcpd_pkg::Y_W-1:0]         y_ff, y_in;
   logic [pcpd_pkg::COLOUR_W-1:0]    colour_ff, colour_in;

   // ---------------------------------------------------------------- handshake
   logic req_fire, advance, work, emit;

   // Move the held byte on whenever the output register is free or draining.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign work       = advance && !failed_ff;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------- decode
   pcpd_pkg::phase_type        cur_phase;
   logic                       cur_none;
   logic [CMP_W-1:0]           bound, height_ext, top_ext, sum_ext, row_ext;
   logic                       is_term, too_long, fail_hit;

   // A start byte opens a new column in any phase: treat it as a top delta.
   assign cur_phase  = s1_start_ff ? pcpd_pkg::PH_TOP : phase_ff;
   assign cur_none   = s1_start_ff ? 1'b1 : top_none_ff;

   assign height_ext = CMP_W'(height_ff);
   assign bound      = (height_ext > CMP_W'(MAX_SIZE)) ? CMP_W'(MAX_SIZE) : height_ext;
   assign top_ext    = CMP_W'(post_top_ff);
   assign sum_ext    = top_ext + CMP_W'(s1_byte_ff);
   assign row_ext    = CMP_W'(row_ff);

   assign is_term    = (s1_byte_ff == pcpd_pkg::TERM_BYTE);
   assign too_long   = (sum_ext > bound);

   // Error on early lump end within a column anywhere but the 0xff end, or on an overlong post.
   always_comb begin
      fail_hit = 1'b0;
      case (cur_phase)
         pcpd_pkg::PH_TOP:   fail_hit = s1_last_ff && !is_term;
         pcpd_pkg::PH_LEN:   fail_hit = s1_last_ff || too_long;
         pcpd_pkg::PH_SKIP1,
         pcpd_pkg::PH_PIX,
         pcpd_pkg::PH_SKIP2: fail_hit = s1_last_ff;
         default:            fail_hit = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      phase_in = phase_ff;
      if (work) begin
         if (fail_hit) begin
            phase_in = pcpd_pkg::PH_IDLE;
         end else begin
            case (cur_phase)
               pcpd_pkg::PH_TOP:   phase_in = is_term ? pcpd_pkg::PH_IDLE : pcpd_pkg::PH_LEN;
               pcpd_pkg::PH_LEN:   phase_in = pcpd_pkg::PH_SKIP1;
               pcpd_pkg::PH_SKIP1: phase_in = (left_ff == '0) ? pcpd_pkg::PH_SKIP2
                                                               : pcpd_pkg::PH_PIX;
               pcpd_pkg::PH_PIX:   phase_in = (left_ff == pcpd_pkg::BYTE_W'(1))
                                              ? pcpd_pkg::PH_SKIP2 : pcpd_pkg::PH_PIX;
               pcpd_pkg::PH_SKIP2: phase_in = pcpd_pkg::PH_TOP;
               default:            phase_in = pcpd_pkg::PH_IDLE;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- datapath and result
   always_comb begin
      top_none_in = top_none_ff;
      post_top_in = post_top_ff;
      row_in      = row_ff;
      left_in     = left_ff;
      failed_in   = failed_ff;
      emit        = 1'b0;
      kind_in     = pcpd_pkg::KIND_PIXEL;
      y_in        = '0;
      colour_in   = '0;
      if (work) begin
         top_none_in = cur_none;
         if (fail_hit) begin
            failed_in = 1'b1;
            emit      = 1'b1;
            kind_in   = pcpd_pkg::KIND_ERROR;
         end else begin
            case (cur_phase)
               pcpd_pkg::PH_TOP: begin
                  if (is_term) begin
                     emit    = 1'b1;
                     kind_in = pcpd_pkg::KIND_DONE;
                  end else begin
                     // tall post: a delta not above the top stacks on it
                     if (!cur_none && (TOP_W'(s1_byte_ff) <= post_top_ff)) begin
                        post_top_in = post_top_ff + TOP_W'(s1_byte_ff);
                     end else begin
                        post_top_in = TOP_W'(s1_byte_ff);
                     end
                     top_none_in = 1'b0;
                  end
               end
               pcpd_pkg::PH_LEN: begin
                  row_in  = post_top_ff;
                  left_in = s1_byte_ff;
               end
               pcpd_pkg::PH_PIX: begin
                  emit      = 1'b1;
                  kind_in   = pcpd_pkg::KIND_PIXEL;
                  y_in      = row_ext[pcpd_pkg::Y_W-1:0];
                  colour_in = ((s1_byte_ff == '0) && remap_ff) ? black_ff : s1_byte_ff;
                  row_in    = row_ff + TOP_W'(1);
                  left_in   = left_ff - pcpd_pkg::BYTE_W'(1);
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Load a fresh result when the output register frees up, else hold.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_in = work && emit;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= pcpd_pkg::PH_IDLE;
         top_none_ff  <= 1'b1;
         post_top_ff  <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         failed_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         top_none_ff  <= top_none_in;
         post_top_ff  <= post_top_in;
         row_ff       <= row_in;
         left_ff      <= left_in;
         failed_ff    <= failed_in;
      end
   end

   // ---------------------------------------------------------------- config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= pcpd_pkg::IMAGE_HEIGHT_RST;
         remap_ff  <= pcpd_pkg::REMAP_ZERO_RST;
         black_ff  <= pcpd_pkg::BLACK_INDEX_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pcpd_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_data;
            pcpd_pkg::REG_REMAP_ZERO:   remap_ff  <= csr_data[0];
            pcpd_pkg::REG_BLACK_INDEX:  black_ff  <= csr_data[pcpd_pkg::BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff  <= req_tdata[pcpd_pkg::BYTE_W-1:0];
         s1_col_ff   <= req_tdata[pcpd_pkg::BYTE_W +: pcpd_pkg::COL_W];
         s1_start_ff <= req_tuser[0];
         s1_last_ff  <= req_tlast;
      end
      if (!rsp_valid_ff || rsp_tready) begin
         kind_ff   <= kind_in;
         x_ff      <= s1_col_ff;
         y_ff      <= y_in;
         colour_ff <= colour_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {2'b00, colour_ff, y_ff, x_ff};

endmodule

### hw/rtl/pcpd_checker.sv
// -----------------------------------------------------------------------------
// pcpd_checker
// Port-level checks of the column-post picture decoder, bound to the top.
// -----------------------------------------------------------------------------
module pcpd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [pcpd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic [pcpd_pkg::REQ_USER_W-1:0]   req_tuser,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pcpd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [pcpd_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [pcpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [pcpd_pkg::CSR_DATA_W-1:0]   csr_data
);

   // Hold a stalled result beat.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // Done and error beats carry zero row and colour.
   a_non_pixel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != pcpd_pkg::KIND_PIXEL) |-> (rsp_tdata[29:11] == '0))
      else $error("done or error beat with row or colour set");

   // Result kind is pixel, done or error.
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == pcpd_pkg::KIND_PIXEL) || (rsp_tuser == pcpd_pkg::KIND_DONE)
                     || (rsp_tuser == pcpd_pkg::KIND_ERROR))
      else $error("illegal result kind");

   // A fresh result follows a request beat that was accepted earlier.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a request beat");

   // Reset drops any pending result.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind patch_column_post_decoder_unit pcpd_checker u_pcpd_checker (.*);

### tb/sv/pcpd_check_pkg.sv
// -----------------------------------------------------------------------------
// pcpd_check_pkg
// Expected-write model and checker for the column-post picture decoder bench.
// -----------------------------------------------------------------------------
package pcpd_check_pkg;
   import pcpd_pkg::*;

   typedef struct packed {
      kind_type              kind;
      logic [COL_W-1:0]      x;
      logic [Y_W-1:0]        y;
      logic [COLOUR_W-1:0]   colour;
   } column_write_type;

   class column_post_board;
      logic [HEIGHT_W-1:0] height;
      logic                remap;
      logic [BYTE_W-1:0]   black;
      phase_type           phase;
      int                  top;
      logic [HEIGHT_W-1:0] row;
      logic [BYTE_W-1:0]   left;
      bit                  halted;
      column_write_type    writes_due[$];
      int                  faults;

      function new();
         height = IMAGE_HEIGHT_RST;
         remap  = REMAP_ZERO_RST;
         black  = BLACK_INDEX_RST;
         phase  = PH_IDLE;
         top    = -1;
         row    = '0;
         left   = '0;
         halted = 1'b0;
         faults = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_IMAGE_HEIGHT: height = val;
            REG_REMAP_ZERO:   remap  = val[0];
            REG_BLACK_INDEX:  black  = val[BYTE_W-1:0];
            default: ;
         endcase
      endfunction

      function void queue_write(kind_type k, logic [COL_W-1:0] x, logic [Y_W-1:0] y,
                                logic [COLOUR_W-1:0] c);
         column_write_type w;
         w.kind   = k;
         w.x      = x;
         w.y      = y;
         w.colour = c;
         writes_due.push_back(w);
      endfunction

      // Error abandons the picture: every later byte is dropped.
      function void abandon(logic [COL_W-1:0] x);
         halted = 1'b1;
         phase  = PH_IDLE;
         queue_write(KIND_ERROR, x, '0, '0);
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b, bit start, logic [COL_W-1:0] x, bit last);
         int bv;
         int bound;
         bv    = b;
         bound = (height > MAX_SIZE_DEF) ? MAX_SIZE_DEF : height;
         if (halted) return;
         if (start) begin
            phase = PH_TOP;
            top   = -1;
         end
         case (phase)
            PH_TOP: begin
               if (b == TERM_BYTE) begin
                  phase = PH_IDLE;
                  queue_write(KIND_DONE, x, '0, '0);
               end else if (last) begin
                  abandon(x);
               end else begin
                  // tall post: a delta not above the top adds to it
                  top   = (bv <= top) ? top + bv : bv;
                  phase = PH_LEN;
               end
            end
            PH_LEN: begin
               if (last || top + bv > bound) begin
                  abandon(x);
               end else begin
                  row   = top;
                  left  = b;
                  phase = PH_SKIP1;
               end
            end
            PH_SKIP1: begin
               if (last) abandon(x);
               else phase = (left == '0) ? PH_SKIP2 : PH_PIX;
            end
            PH_PIX: begin
               if (last) begin
                  abandon(x);
               end else begin
                  queue_write(KIND_PIXEL, x, row[Y_W-1:0], (b == '0 && remap) ? black : b);
                  row  = row + 1'b1;
                  left = left - 1'b1;
                  if (left == '0) phase = PH_SKIP2;
               end
            end
            PH_SKIP2: begin
               if (last) abandon(x);
               else phase = PH_TOP;
            end
            default: ;
         endcase
      endfunction

      function void check_write(logic [KIND_W-1:0] kind, logic [COL_W-1:0] x,
                                logic [Y_W-1:0] y, logic [COLOUR_W-1:0] colour);
         column_write_type want;
         if (writes_due.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected result: kind %0d x %0d y %0d colour %0d",
                        kind, x, y, colour);
            return;
         end
         want = writes_due.pop_front();
         if (want.kind !== kind || want.x !== x || want.y !== y || want.colour !== colour) begin
            faults++;
            if (faults <= 10)
               $display("result mismatch: expected kind %0d x %0d y %0d colour %0d, %s",
                        want.kind, want.x, want.y, want.colour,
                        $sformatf("got kind %0d x %0d y %0d colour %0d", kind, x, y, colour));
         end
      endfunction
   endclass

endpackage

### tb/sv/patch_column_post_decoder_unit_tb.sv
// -----------------------------------------------------------------------------
// patch_column_post_decoder_unit_tb
// Self-checking bench for the column-post picture decoder.
// -----------------------------------------------------------------------------
// Feeds column data byte by byte: a directed opening (ignored stray bytes,
// zero remap, tall posts, a column restarted mid-post), then random legal
// columns under several height and remap settings, with stray bytes and
// abandoned columns mixed in. Errors are sticky until reset, so exactly one
// failing column (a lump cut short in some phase, or a post too long) closes
// the run. Every accepted byte runs through a model of the post walker and
// every result beat is compared field by field with the oldest expectation.
// -----------------------------------------------------------------------------
module patch_column_post_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pcpd_pkg::*;
   import pcpd_check_pkg::*;

   localparam int PERIOD        = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 6;     // result passes the input and output registers, plus margin
   localparam int LONG_HOLD     = 400;   // receiver hold-off, in cycles
   localparam int QUIET_LIMIT   = 3000;  // cycles without any beat

   typedef enum int {
      CUT_AT_TOP,
      CUT_AT_LEN,
      CUT_AT_SKIP1,
      CUT_AT_PIXEL,
      CUT_AT_SKIP2,
      POST_TOO_LONG
   } failure_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [7:0] data_byte, [18:8] column
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // [0] column_start
   logic                  req_tlast  = 1'b0; // lump_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [10:0] pixel_x, [21:11] pixel_y, [29:22] colour
   logic [RSP_USER_W-1:0] rsp_tuser;         // [1:0] kind
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   column_post_board board;
   bit               calm       = 1'b0;  // no idling on either side once set
   int               fed        = 0;     // column bytes sent, strays excluded
   int               rows_bound = 1;     // height limit the generator respects

   patch_column_post_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic int least(int a, int b);
      return (a < b) ? a : b;
   endfunction

   // Offer one byte, hold it until the beat, then feed it to the model.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit start,
                            input logic [COL_W-1:0] x, input bit last);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - BYTE_W - COL_W){1'b0}}, x, b};
      req_tuser  <= start;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_byte(b, start, x, last);
   endtask

   // Write all three registers back to back, keeping valid high between beats.
   task automatic write_config(input logic [HEIGHT_W-1:0] h, input logic r,
                               input logic [BYTE_W-1:0] k);
      logic [CSR_IDX_W-1:0]  regs [3];
      logic [CSR_DATA_W-1:0] vals [3];
      regs = '{REG_IMAGE_HEIGHT, REG_REMAP_ZERO, REG_BLACK_INDEX};
      vals = '{h, CSR_DATA_W'(r), CSR_DATA_W'(k)};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         board.set_reg(regs[i], vals[i]);
      end
      csr_valid  <= 1'b0;
      rows_bound = least(h, MAX_SIZE_DEF);
   endtask

   // Drop valid, wait for every expected beat, then let the pipe empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.writes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Build a legal column against rows_bound and send it; when cut, stop
   // partway so the next column start drops it.
   task automatic send_column(input bit cut);
      logic [BYTE_W-1:0] col_bytes[$];
      logic [COL_W-1:0]  x;
      int                top;
      int                delta;
      int                len;
      int                posts;
      int                stop;
      bit                end_lump;
      x     = $urandom_range(0, 2047);
      top   = -1;
      posts = $urandom_range(0, 4);
      for (int p = 0; p < posts; p++) begin
         if (top < 0) begin
            delta = $urandom_range(0, least(254, rows_bound));
            top   = delta;
         end else if (top >= least(254, rows_bound) || $urandom_range(0, 2) != 0) begin
            // tall post: delta stays within the current top
            delta = $urandom_range(0, least(top, least(254, rows_bound - top)));
            top   = top + delta;
         end else begin
            delta = $urandom_range(top + 1, least(254, rows_bound));
            top   = delta;
         end
         len = $urandom_range(0, least(rows_bound - top,
                                       ($urandom_range(0, 19) == 0) ? 255 : 6));
         col_bytes.push_back(BYTE_W'(delta));
         col_bytes.push_back(BYTE_W'(len));
         col_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
         repeat (len)
            col_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
         col_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      end
      col_bytes.push_back(TERM_BYTE);
      stop     = (cut && col_bytes.size() > 1) ? $urandom_range(1, col_bytes.size() - 1)
                                               : col_bytes.size();
      end_lump = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < stop; i++)
         send_byte(col_bytes[i], i == 0, x,
                   stop == col_bytes.size() && i == stop - 1 && end_lump);
      fed += stop;
   endtask

   // Bytes between columns without a start: the block must drop them.
   task automatic send_strays();
      repeat ($urandom_range(1, 3))
         send_byte(8'($urandom_range(0, 255)), 1'b0, 11'($urandom_range(0, 2047)),
                   $urandom_range(0, 1));
   endtask

   task automatic feed_columns(input int quota);
      int target;
      bit cut;
      target = fed + quota;
      while (fed < target) begin
         cut = ($urandom_range(0, 7) == 0);
         send_column(cut);
         if (!cut && $urandom_range(0, 4) == 0) send_strays();
      end
   endtask

   // One column that ends in an error, then bytes the halted block ignores.
   task automatic send_failure();
      logic [BYTE_W-1:0] col_bytes[$];
      logic [COL_W-1:0]  x;
      failure_mode_type  mode;
      int                top;
      int                len;
      int                stop;
      x    = $urandom_range(0, 2047);
      mode = failure_mode_type'($urandom_range(0, 5));
      top  = $urandom_range(0, least(254, rows_bound - 1));
      len  = $urandom_range(1, least(rows_bound - top, 8));
      col_bytes.push_back(BYTE_W'(top));
      col_bytes.push_back(BYTE_W'(len));
      col_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      repeat (len) col_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      col_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      case (mode)
         CUT_AT_TOP: begin
            col_bytes.push_back(BYTE_W'($urandom_range(0, 254)));
            stop = col_bytes.size() - 1;
         end
         CUT_AT_LEN:   stop = 1;
         CUT_AT_SKIP1: stop = 2;
         CUT_AT_PIXEL: stop = len + 2;   // last pixel of the post
         CUT_AT_SKIP2: stop = len + 3;
         default: begin
            col_bytes[1] = BYTE_W'($urandom_range(rows_bound - top + 1, 255));
            stop = 1;
         end
      endcase
      for (int i = 0; i <= stop; i++)
         send_byte(col_bytes[i], i == 0, x, i == stop && mode != POST_TOO_LONG);
      fed += stop + 1;
      send_byte(TERM_BYTE, 1'b1, x, 1'b0);
      send_byte(8'h00, 1'b1, x, 1'b1);
   endtask

   // Receiver: check each result beat, then pick next cycle's tready.
   initial begin : rsp_side
      int stall;
      int seen;
      bit held;
      stall = 0;
      seen  = 0;
      held  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            board.check_write(rsp_tuser, rsp_tdata[10:0], rsp_tdata[21:11], rsp_tdata[29:22]);
            seen++;
         end
         // one long hold-off early on, so the block fills and backs up its input
         if (!held && seen >= 60) begin
            held  = 1'b1;
            stall = LONG_HOLD;
         end else if (stall == 0 && !calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 5);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no beat of any kind moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("patch_column_post_decoder_unit verification failed");
      $finish;
   end

   initial begin : stimulus
      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening at full height with remap on.
      write_config(12'd2048, 1'b1, 8'hA5);
      send_byte(8'h00, 1'b0, 11'h7FF, 1'b1);   // stray while idle, lump end too
      send_byte(8'h00, 1'b1, 11'h000, 1'b0);   // first delta replaces minus one
      send_byte(8'h02, 1'b0, 11'h000, 1'b0);
      send_byte(8'hFF, 1'b0, 11'h000, 1'b0);
      send_byte(8'h00, 1'b0, 11'h000, 1'b0);   // colour 0 becomes black index
      send_byte(8'hFF, 1'b0, 11'h000, 1'b0);   // 0xff as a pixel is just a colour
      send_byte(8'h00, 1'b0, 11'h000, 1'b0);
      send_byte(8'h00, 1'b0, 11'h000, 1'b0);   // delta equal to top: added
      send_byte(8'h01, 1'b0, 11'h000, 1'b0);
      send_byte(8'h55, 1'b0, 11'h000, 1'b0);
      send_byte(8'h80, 1'b0, 11'h000, 1'b0);
      send_byte(8'hAA, 1'b0, 11'h000, 1'b0);
      send_byte(8'hFE, 1'b0, 11'h000, 1'b0);   // replaces
      send_byte(8'h00, 1'b0, 11'h000, 1'b0);   // empty post
      send_byte(8'h12, 1'b0, 11'h000, 1'b0);
      send_byte(8'h34, 1'b0, 11'h000, 1'b0);
      send_byte(8'hFE, 1'b0, 11'h000, 1'b0);   // tall: top goes to 508
      send_byte(8'h01, 1'b0, 11'h000, 1'b0);
      send_byte(8'h00, 1'b0, 11'h000, 1'b0);
      send_byte(8'h01, 1'b0, 11'h000, 1'b0);
      send_byte(8'h00, 1'b0, 11'h000, 1'b0);
      send_byte(TERM_BYTE, 1'b0, 11'h000, 1'b1);  // column end on the lump end
      send_byte(8'h10, 1'b1, 11'h555, 1'b0);
      send_byte(8'h03, 1'b0, 11'h555, 1'b0);
      send_byte(8'h00, 1'b0, 11'h555, 1'b0);
      send_byte(8'h33, 1'b0, 11'h555, 1'b0);
      send_byte(TERM_BYTE, 1'b1, 11'h2AA, 1'b0);  // restart drops the open post
      settle();

      // Random columns under a spread of settings.
      write_config(12'd2048, 1'b1, 8'hFF);
      feed_columns(320);
      settle();
      write_config(12'd1, 1'b0, 8'h00);
      feed_columns(320);
      settle();
      write_config(12'hFFF, 1'b1, 8'($urandom_range(0, 255)));   // clamps to MAX_SIZE
      feed_columns(320);
      settle();
      write_config(12'($urandom_range(1, 2048)), $urandom_range(0, 1),
                   8'($urandom_range(0, 255)));
      feed_columns(320);
      settle();
      calm = 1'b1;
      write_config(12'd2048, 1'b0, 8'($urandom_range(0, 255)));
      feed_columns(250);
      settle();

      // Short picture, one good column, then the error that halts the block.
      write_config(12'($urandom_range(1, 200)), $urandom_range(0, 1),
                   8'($urandom_range(0, 255)));
      send_column(1'b0);
      send_failure();
      settle();

      if (board.faults == 0 && board.writes_due.size() == 0) begin
         $display("patch_column_post_decoder_unit verification clean");
      end else begin
         $display("patch_column_post_decoder_unit verification failed");
      end
      $finish;
   end

endmodule
